// ===== src/vnc_pkg.sv =====
package vnc_pkg;

  // Default sizing
  localparam int LatticeDimDef = 256;
  localparam int ImageDimDef   = 512;
  localparam int WeightBitsDef = 10;

  // Fixed field widths
  localparam int CsW   = 10;
  localparam int ValW  = 16;
  localparam int WgtW  = 17;

  localparam longint unsigned Q30One    = 64'd1073741824;
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_AMPLITUDE = 2'd0,
    REG_CELL_X    = 2'd1,
    REG_CELL_Y    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    op_e         operation;
    logic [7:0]  lattice_x;
    logic [7:0]  lattice_y;
    logic [15:0] unit_random;
    logic [8:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [15:0] prior_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] pixel_value;
    logic        saturated;
  } out_item_t;

  // Per-item control travelling alongside the dividers
  typedef struct packed {
    logic        vld;
    op_e         op;
    logic [15:0] prior;
    logic [15:0] ld_val;
    logic [7:0]  ld_x;
    logic [7:0]  ld_y;
  } side_t;

  // sin^2(pi*t/2) in Q0.16, Taylor series in Q2.30; elaboration only
  function automatic longint unsigned half_weight(longint unsigned t);
    longint unsigned a, x2, r, s, sq;
    a  = (t * HalfPiQ30) >> 16;
    x2 = (a * a) >> 30;
    r  = Q30One;
    r  = Q30One - ((x2 * r) >> 30) / 110;
    r  = Q30One - ((x2 * r) >> 30) / 72;
    r  = Q30One - ((x2 * r) >> 30) / 42;
    r  = Q30One - ((x2 * r) >> 30) / 20;
    r  = Q30One - ((x2 * r) >> 30) / 6;
    s  = (a * r) >> 30;
    sq = (s * s) >> 30;
    return (sq + 64'd8192) >> 14;
  endfunction

  // Cosine weight table entry, Q1.16 (0..65536)
  function automatic logic [WgtW-1:0] weight_of(int idx, int wbits);
    longint unsigned t;
    longint unsigned w;
    t = longint'(idx & ((1 << wbits) - 1)) << (16 - wbits);
    if (t <= 64'd32768) begin
      w = half_weight(t);
    end else begin
      w = 64'd65536 - half_weight(64'd65536 - t);
    end
    return w[WgtW-1:0];
  endfunction

  // a*(1-w) + b*w, rounded, written as a + (b-a)*w
  function automatic logic [ValW-1:0] blend(logic [ValW-1:0] a, logic [ValW-1:0] b,
                                            logic [WgtW-1:0] w);
    logic signed [17:0] diff;
    logic signed [35:0] prod;
    logic signed [35:0] s;
    diff = signed'({2'b00, b}) - signed'({2'b00, a});
    prod = 36'(diff) * 36'(signed'({1'b0, w}));
    s    = signed'({4'b0000, a, 16'h0000}) + prod + 36'sd32768;
    return s[31:16];
  endfunction

endpackage

// ===== src/vnc_ram.sv =====
module vnc_ram #(
  parameter int Width = 16,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

// ===== src/vnc_divider.sv =====
module vnc_divider #(
  parameter int QuotBits = 19
) (
  input  logic                       clk_i,
  input  logic                       adv_i,
  input  logic [QuotBits-1:0]        dividend_i,
  input  logic [vnc_pkg::CsW-1:0]    divisor_i,
  output logic [QuotBits-1:0]        quot_o
);
  import vnc_pkg::*;

  // Restoring long division, one quotient bit per stage
  logic [CsW-1:0]      rem_q [QuotBits];
  logic [QuotBits-1:0] quo_q [QuotBits];
  logic [QuotBits-1:0] dvd_q [QuotBits];
  logic [CsW-1:0]      dvs_q [QuotBits];

  for (genvar k = 0; k < QuotBits; k++) begin : g_stage
    logic [CsW-1:0]      rem_in;
    logic [QuotBits-1:0] quo_in;
    logic [QuotBits-1:0] dvd_in;
    logic [CsW-1:0]      dvs_in;
    logic [CsW:0]        trial;
    logic                qbit;
    logic [CsW:0]        rem_next;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign quo_in = '0;
      assign dvd_in = dividend_i;
      assign dvs_in = divisor_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
      assign dvd_in = dvd_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end

    assign trial    = {rem_in, dvd_in[QuotBits-1]};
    assign qbit     = (trial >= {1'b0, dvs_in});
    assign rem_next = qbit ? (trial - {1'b0, dvs_in}) : trial;

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[k] <= rem_next[CsW-1:0];
        quo_q[k] <= {quo_in[QuotBits-2:0], qbit};
        dvd_q[k] <= {dvd_in[QuotBits-2:0], 1'b0};
        dvs_q[k] <= dvs_in;
      end
    end
  end

  assign quot_o = quo_q[QuotBits-1];

endmodule

// ===== src/vnc_out_fifo.sv =====
module vnc_out_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  vnc_pkg::out_item_t  data_i,
  output logic                full_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output vnc_pkg::out_item_t  out_data_o
);
  import vnc_pkg::*;

  out_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop)) else $error("result buffer overflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result buffer count out of range");

endmodule

// ===== src/value_noise_cosine_layer_unit.sv =====
// Value noise layer, one octave, cosine interpolation.
// Input channel in_valid_i/in_ready_o carries in_data_i. A load item scales
// unit_random by the amplitude register and stores it at a lattice point; an
// evaluate item returns prior_value plus interpolated noise, saturated.
// Output channel out_valid_o/out_ready_i carries one result per evaluate;
// loads give no result. Registers are written through cfg_valid_i/cfg_index_i/
// cfg_data_i, always ready; write them only while the block is idle (the block itself does not enforce this).
// Throughput: one item per cycle while the result buffer is not full. An
// evaluate passes through the two cell dividers, which produce one quotient
// bit per stage, then a lattice read, two blend stages and the result buffer.
// Four lattice values come from two copies of the lattice memory, each with
// two read ports; loads write both copies at the read stage, in item order.
// Reset returns the registers to amplitude 1 and cell sizes 1 and empties the
// pipeline; the lattice memory is not cleared and must be loaded before use.
// When the receiver stalls, a two-entry result buffer keeps taking results;
// once it is full the whole pipeline holds and in_ready_o drops.
module value_noise_cosine_layer_unit #(
  parameter int LATTICE_DIM = vnc_pkg::LatticeDimDef,
  parameter int IMAGE_DIM   = vnc_pkg::ImageDimDef,
  parameter int WEIGHT_BITS = vnc_pkg::WeightBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vnc_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vnc_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [9:0]         cfg_data_i
);
  import vnc_pkg::*;

  localparam int PXW = (IMAGE_DIM > 2) ? $clog2(IMAGE_DIM) : 1;
  localparam int LAW = (LATTICE_DIM > 2) ? $clog2(LATTICE_DIM) : 1;
  localparam int AW  = $clog2(LATTICE_DIM * LATTICE_DIM);
  localparam int NQ  = PXW + WEIGHT_BITS;
  localparam int WTN = 2 ** WEIGHT_BITS;

  // Configuration registers
  logic [7:0]     amp_q;
  logic [CsW-1:0] csx_q, csy_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q <= 8'd1;
      csx_q <= 10'd1;
      csy_q <= 10'd1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_AMPLITUDE: amp_q <= cfg_data_i[7:0];
        REG_CELL_X:    csx_q <= cfg_data_i;
        REG_CELL_Y:    csy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: held only when the result buffer is full
  logic fifo_full;
  logic adv;
  assign adv        = !fifo_full;
  assign in_ready_o = adv;

  // Input preparation: clamps, zero cell size acts as one, load value
  logic [PXW-1:0] px_c, py_c;
  logic [CsW-1:0] csx_eff, csy_eff;
  logic [23:0]    ld_prod;
  side_t          side_in;

  always_comb begin
    px_c = (32'(in_data_i.pixel_x) > 32'(IMAGE_DIM - 1)) ?
           PXW'(IMAGE_DIM - 1) : PXW'(in_data_i.pixel_x);
    py_c = (32'(in_data_i.pixel_y) > 32'(IMAGE_DIM - 1)) ?
           PXW'(IMAGE_DIM - 1) : PXW'(in_data_i.pixel_y);
    csx_eff = (csx_q == '0) ? CsW'(1) : csx_q;
    csy_eff = (csy_q == '0) ? CsW'(1) : csy_q;
    ld_prod = 24'(in_data_i.unit_random) * 24'(amp_q);
    side_in.vld    = in_valid_i;
    side_in.op     = in_data_i.operation;
    side_in.prior  = in_data_i.prior_value;
    side_in.ld_val = ld_prod[23:8];
    side_in.ld_x   = (32'(in_data_i.lattice_x) > 32'(LATTICE_DIM - 1)) ?
                     8'(LATTICE_DIM - 1) : in_data_i.lattice_x;
    side_in.ld_y   = (32'(in_data_i.lattice_y) > 32'(LATTICE_DIM - 1)) ?
                     8'(LATTICE_DIM - 1) : in_data_i.lattice_y;
  end

  // Cell index and fraction index from one long division per axis
  logic [NQ-1:0] qx, qy;

  vnc_divider #(.QuotBits(NQ)) u_div_x (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .dividend_i ({px_c, WEIGHT_BITS'(0)}),
    .divisor_i  (csx_eff),
    .quot_o     (qx)
  );

  vnc_divider #(.QuotBits(NQ)) u_div_y (
    .clk_i      (clk_i),
    .adv_i      (adv),
    .dividend_i ({py_c, WEIGHT_BITS'(0)}),
    .divisor_i  (csy_eff),
    .quot_o     (qy)
  );

  // Item control alongside the divider stages
  side_t sb_q [NQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NQ; k++) begin
        sb_q[k] <= '0;
      end
    end else if (adv) begin
      sb_q[0] <= side_in;
      for (int k = 1; k < NQ; k++) begin
        sb_q[k] <= sb_q[k-1];
      end
    end
  end

  // Lattice corners, clamped to the lattice
  logic [PXW-1:0] x0_raw, y0_raw;
  logic [LAW-1:0] x0, x1, y0, y1;
  logic [AW-1:0]  a00, a10, a01, a11, waddr;
  logic           lat_we;
  side_t          sb_end;

  assign sb_end = sb_q[NQ-1];

  always_comb begin
    x0_raw = qx[NQ-1:WEIGHT_BITS];
    y0_raw = qy[NQ-1:WEIGHT_BITS];
    x0 = (32'(x0_raw) > 32'(LATTICE_DIM - 1)) ? LAW'(LATTICE_DIM - 1) : LAW'(x0_raw);
    y0 = (32'(y0_raw) > 32'(LATTICE_DIM - 1)) ? LAW'(LATTICE_DIM - 1) : LAW'(y0_raw);
    x1 = (x0 == LAW'(LATTICE_DIM - 1)) ? x0 : x0 + LAW'(1);
    y1 = (y0 == LAW'(LATTICE_DIM - 1)) ? y0 : y0 + LAW'(1);
    a00   = AW'(y0) * AW'(LATTICE_DIM) + AW'(x0);
    a10   = AW'(y0) * AW'(LATTICE_DIM) + AW'(x1);
    a01   = AW'(y1) * AW'(LATTICE_DIM) + AW'(x0);
    a11   = AW'(y1) * AW'(LATTICE_DIM) + AW'(x1);
    waddr = AW'(sb_end.ld_y) * AW'(LATTICE_DIM) + AW'(sb_end.ld_x);
    lat_we = adv && sb_end.vld && (sb_end.op == OP_LOAD);
  end

  // Two copies of the lattice: upper row pair and lower row pair
  logic [ValW-1:0] v00, v10, v01, v11;

  vnc_ram #(.Width(ValW), .Depth(LATTICE_DIM * LATTICE_DIM)) u_lat_top (
    .clk_i     (clk_i),
    .we_i      (lat_we),
    .waddr_i   (waddr),
    .wdata_i   (sb_end.ld_val),
    .re_i      (adv),
    .raddr_a_i (a00),
    .raddr_b_i (a10),
    .rdata_a_o (v00),
    .rdata_b_o (v10)
  );

  vnc_ram #(.Width(ValW), .Depth(LATTICE_DIM * LATTICE_DIM)) u_lat_bot (
    .clk_i     (clk_i),
    .we_i      (lat_we),
    .waddr_i   (waddr),
    .wdata_i   (sb_end.ld_val),
    .re_i      (adv),
    .raddr_a_i (a01),
    .raddr_b_i (a11),
    .rdata_a_o (v01),
    .rdata_b_o (v11)
  );

  // Cosine weight table, filled at elaboration
  logic [WgtW-1:0] wtab [WTN];

  for (genvar i = 0; i < WTN; i++) begin : g_wtab
    assign wtab[i] = weight_of(i, WEIGHT_BITS);
  end

  // Read stage: weights registered next to the lattice data
  logic [WgtW-1:0] wx1_q, wy1_q;
  logic [15:0]     prior1_q;
  logic            vld1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (adv) begin
      vld1_q <= sb_end.vld && (sb_end.op == OP_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      wx1_q    <= wtab[qx[WEIGHT_BITS-1:0]];
      wy1_q    <= wtab[qy[WEIGHT_BITS-1:0]];
      prior1_q <= sb_end.prior;
    end
  end

  // Blend along x
  logic [ValW-1:0] top2_q, bot2_q;
  logic [WgtW-1:0] wy2_q;
  logic [15:0]     prior2_q;
  logic            vld2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (adv) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      top2_q   <= blend(v00, v10, wx1_q);
      bot2_q   <= blend(v01, v11, wx1_q);
      wy2_q    <= wy1_q;
      prior2_q <= prior1_q;
    end
  end

  // Blend along y
  logic [ValW-1:0] noise3_q;
  logic [15:0]     prior3_q;
  logic            vld3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (adv) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      noise3_q <= blend(top2_q, bot2_q, wy2_q);
      prior3_q <= prior2_q;
    end
  end

  // Accumulate and saturate into the result buffer
  logic [16:0] sum;
  out_item_t   res;
  logic        push;

  always_comb begin
    sum             = 17'(prior3_q) + 17'(noise3_q);
    res.saturated   = sum[16];
    res.pixel_value = sum[16] ? 16'hFFFF : sum[15:0];
    push            = adv && vld3_q;
  end

  vnc_out_fifo u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (res),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_sat_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.pixel_value == 16'hFFFF)
    else $error("saturated result not at maximum");
  a_hold_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_full |=> $stable(vld3_q) && $stable(noise3_q))
    else $error("pipeline moved while result buffer full");
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && sb_end.vld && sb_end.op == OP_LOAD |=> !vld1_q)
    else $error("load item produced a result");

endmodule
